// ===== hw/rtl/atbq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the box table query block.
// No dependencies; every other file in the block imports this package.
package atbq_pkg;

   localparam int MAX_BODIES = 32;
   localparam int RESULT_CAP = 32;
   localparam int SLOT_W     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int EMIT_W     = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;

   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [2:0] STATUS_UPDATED  = 3'd0;
   localparam logic [2:0] STATUS_INSERTED = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_REMOVED  = 3'd3;
   localparam logic [2:0] STATUS_ABSENT   = 3'd4;
   localparam logic [2:0] STATUS_HIT      = 3'd5;
   localparam logic [2:0] STATUS_NOHIT    = 3'd6;

   typedef struct packed {
      logic        [1:0]  command;
      logic        [31:0] id;
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] hit_id;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
   } box_type;

   typedef struct packed {
      logic [31:0] id;
      box_type     box;
   } entry_type;

   typedef struct packed {
      logic id_match;
      logic overlap;
   } eval_type;

endpackage

// ===== hw/rtl/atbq_slot_eval.sv =====
`timescale 1ns / 1ps
// Compares one stored slot against the held command word: id equality
// and inclusive box overlap on both axes. Depends on atbq_pkg.
module atbq_slot_eval
   import atbq_pkg::*;
(
   input  entry_type entry,
   input  req_type   req,
   output eval_type  result
);

   assign result.id_match = (entry.id == req.id);

   // edges touching count as overlap
   assign result.overlap = (entry.box.min_x <= req.max_x) && (entry.box.max_x >= req.min_x) &&
                           (entry.box.min_y <= req.max_y) && (entry.box.max_y >= req.min_y);

endmodule

// ===== hw/rtl/aabb_table_box_query_core.sv =====
`timescale 1ns / 1ps
// Box table with overlap query: top level, slot memory and sequencer.
// Depends on atbq_pkg and atbq_slot_eval.

// A word is taken when start is high and busy is low; busy stays high until
// the last result of that word shows on the result ports. Ids and boxes live in a
// slot memory with a read port and a write port, read one slot per cycle, so
// every pass over the table reads all MAX_BODIES slots. Update and remove take
// one pass: busy is already low in the cycle that the result strobes, and the
// next word can be taken at the edge that ends that cycle. A query runs one pass
// per hit, up to RESULT_CAP hits, choosing the smallest remaining id each time,
// so its hits arrive one per pass and a query without hits answers after one pass.
// Results show for a single cycle on rsp_strobe and are not held; the
// receiver must take them as they come. Command code 3 is taken and dropped.
module aabb_table_box_query_core
   import atbq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [MAX_BODIES-1:0] valid_ff, valid_in;
   logic [MAX_BODIES-1:0] mask_ff, mask_in;
   logic [SLOT_W-1:0]     addr_ff, addr_in;
   logic                  issue_ff, issue_in;
   logic                  rd_on_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   entry_type             rdata_ff;
   logic                  first_ff, first_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     found_slot_ff, found_slot_in;
   logic                  free_ff, free_in;
   logic [SLOT_W-1:0]     free_slot_ff, free_slot_in;
   logic [31:0]           best_id_ff, best_id_in;
   logic [EMIT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   entry_type             wr_data;
   eval_type              eval;

   entry_type mem [MAX_BODIES];

   atbq_slot_eval u_eval (
      .entry  (rdata_ff),
      .req    (req_ff),
      .result (eval)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_comb begin
      logic cand;
      logic slot_valid;
      logic last_hit;

      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      mask_in       = mask_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      best_id_in    = best_id_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = found_slot_ff;
      wr_data.id    = req_ff.id;
      wr_data.box   = {req_ff.min_x, req_ff.min_y, req_ff.max_x, req_ff.max_y};
      cand          = 1'b0;
      slot_valid    = valid_ff[rd_slot_ff];
      last_hit      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command inside {CMD_UPDATE, CMD_REMOVE, CMD_QUERY}) begin
                  state_in    = S_SCAN;
                  addr_in     = '0;
                  issue_in    = 1'b1;
                  first_in    = 1'b1;
                  found_in    = 1'b0;
                  free_in     = 1'b0;
                  mask_in     = '0;
                  emit_cnt_in = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               if (addr_ff == SLOT_W'(MAX_BODIES - 1)) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (rd_on_ff) begin
               case (req_ff.command)
                  CMD_QUERY: begin
                     // first pass marks overlapping slots; later passes revisit the marks
                     cand = first_ff ? (slot_valid && eval.overlap) : mask_ff[rd_slot_ff];
                     if (first_ff && cand) begin
                        mask_in[rd_slot_ff] = 1'b1;
                     end
                     if (cand && (!found_ff || (rdata_ff.id < best_id_ff))) begin
                        found_in      = 1'b1;
                        found_slot_in = rd_slot_ff;
                        best_id_in    = rdata_ff.id;
                     end
                  end
                  default: begin
                     if (slot_valid && eval.id_match) begin
                        found_in      = 1'b1;
                        found_slot_in = rd_slot_ff;
                     end
                     if (!slot_valid && !free_ff) begin
                        free_in      = 1'b1;
                        free_slot_in = rd_slot_ff;
                     end
                  end
               endcase

               if (rd_slot_ff == SLOT_W'(MAX_BODIES - 1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.hit_id = '0;
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
                  case (req_ff.command)
                     CMD_UPDATE: begin
                        if (found_in) begin
                           wr_en         = 1'b1;
                           wr_addr       = found_slot_in;
                           rsp_in.status = STATUS_UPDATED;
                        end else if (free_in) begin
                           wr_en                  = 1'b1;
                           wr_addr                = free_slot_in;
                           valid_in[free_slot_in] = 1'b1;
                           rsp_in.status          = STATUS_INSERTED;
                        end else begin
                           rsp_in.status = STATUS_FULL;
                        end
                     end
                     CMD_REMOVE: begin
                        if (found_in) begin
                           valid_in[found_slot_in] = 1'b0;
                           rsp_in.status           = STATUS_REMOVED;
                        end else begin
                           rsp_in.status = STATUS_ABSENT;
                        end
                     end
                     default: begin
                        if (!found_in) begin
                           rsp_in.status = STATUS_NOHIT;
                        end else begin
                           // drop the chosen slot; stop when none remain or at the cap
                           mask_in[found_slot_in] = 1'b0;
                           last_hit = (mask_in == '0) ||
                                      (emit_cnt_ff == EMIT_W'(RESULT_CAP - 1));
                           rsp_in.status = STATUS_HIT;
                           rsp_in.hit_id = best_id_in;
                           rsp_in.last   = last_hit;
                           if (!last_hit) begin
                              state_in    = S_SCAN;
                              emit_cnt_in = emit_cnt_ff + 1'b1;
                              first_in    = 1'b0;
                              found_in    = 1'b0;
                              issue_in    = 1'b1;
                              addr_in     = '0;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         issue_ff      <= 1'b0;
         rd_on_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         issue_ff      <= issue_in;
         rd_on_ff      <= issue_ff;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff        <= req_in;
      mask_ff       <= mask_in;
      addr_ff       <= addr_in;
      rd_slot_ff    <= addr_ff;
      first_ff      <= first_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      best_id_ff    <= best_id_in;
      emit_cnt_ff   <= emit_cnt_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hw/rtl/atbq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the box table query block, bound to the top level.
// Depends on atbq_pkg and aabb_table_box_query_core.
module atbq_checker
   import atbq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic        open_ff;
   logic [31:0] prev_id_ff;

   // track a query that has put out hits but not yet its last one
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (rsp_strobe) begin
         open_ff <= (rsp_data.status == STATUS_HIT) && !rsp_data.last;
      end
      if (rsp_strobe) begin
         prev_id_ff <= rsp_data.hit_id;
      end
   end

   a_single_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != STATUS_HIT) |-> rsp_data.last)
      else $error("non-hit result without last");

   a_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a word in progress");

   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("busy dropped before the last result");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && open_ff |-> (rsp_data.status == STATUS_HIT) &&
                                (rsp_data.hit_id > prev_id_ff))
      else $error("query hits out of ascending id order");

endmodule

bind aabb_table_box_query_core atbq_checker u_atbq_checker (.*);

// ===== tb/aabb_table_box_query_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for aabb_table_box_query_core: directed table, then random
// insert/remove/query traffic; answers checked against a box table or a fixed status.
// Depends on atbq_pkg and the RTL of the block.
module aabb_table_box_query_core_test;
   import atbq_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         POOL_SIZE    = 48;
   localparam int         PASS_CYCLES  = MAX_BODIES + 1;
   localparam int         MAX_GAP      = 18;
   localparam int         REPORT_LIMIT = 10;
   localparam box_type    FULL_BOX     = '{32'h80000000, 32'h80000000,
                                           32'h7FFFFFFF, 32'h7FFFFFFF};

   typedef struct {
      req_type    word;
      bit         typed;
      logic [2:0] status;
   } stim_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // in-bench copy of the slot table
   logic        shadow_valid [MAX_BODIES];
   logic [31:0] shadow_id    [MAX_BODIES];
   box_type     shadow_box   [MAX_BODIES];

   rsp_type      awaited_answers [$];
   stim_row_type directed_rows   [$];
   logic [31:0]  id_pool [POOL_SIZE];

   int unsigned taken_words = 0;
   int unsigned fail_count  = 0;
   bit          cur_typed   = 1'b0;
   logic [2:0]  cur_status  = STATUS_UPDATED;

   aabb_table_box_query_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
   endfunction

   function automatic void push_answer(input logic [2:0] status, input logic [31:0] hit,
                                       input logic last, input bit record);
      rsp_type ans;
      ans.status = status;
      ans.hit_id = hit;
      ans.last   = last;
      if (record) awaited_answers = {awaited_answers, ans};
   endfunction

   // Advance the table by one word; queue its answers when record is set.
   function automatic void advance_table(input req_type w, input bit record);
      int          slot;
      int          free_slot;
      logic [31:0] hit_ids [$];
      int          n;
      slot      = -1;
      free_slot = -1;
      for (int i = MAX_BODIES - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_id[i] == w.id) slot = i;
         if (!shadow_valid[i]) free_slot = i;
      end
      case (w.command)
         CMD_UPDATE: begin
            if (slot >= 0) begin
               shadow_box[slot] = '{w.min_x, w.min_y, w.max_x, w.max_y};
               push_answer(STATUS_UPDATED, '0, 1'b1, record);
            end else if (free_slot >= 0) begin
               shadow_valid[free_slot] = 1'b1;
               shadow_id[free_slot]    = w.id;
               shadow_box[free_slot]   = '{w.min_x, w.min_y, w.max_x, w.max_y};
               push_answer(STATUS_INSERTED, '0, 1'b1, record);
            end else begin
               push_answer(STATUS_FULL, '0, 1'b1, record);
            end
         end
         CMD_REMOVE: begin
            if (slot >= 0) begin
               shadow_valid[slot] = 1'b0;
               push_answer(STATUS_REMOVED, '0, 1'b1, record);
            end else begin
               push_answer(STATUS_ABSENT, '0, 1'b1, record);
            end
         end
         CMD_QUERY: begin
            for (int i = 0; i < MAX_BODIES; i++)
               if (shadow_valid[i] &&
                   shadow_box[i].min_x <= w.max_x && shadow_box[i].max_x >= w.min_x &&
                   shadow_box[i].min_y <= w.max_y && shadow_box[i].max_y >= w.min_y)
                  hit_ids = {hit_ids, shadow_id[i]};
            if (hit_ids.size() == 0) begin
               push_answer(STATUS_NOHIT, '0, 1'b1, record);
            end else begin
               hit_ids.sort();
               n = (hit_ids.size() > RESULT_CAP) ? RESULT_CAP : hit_ids.size();
               for (int k = 0; k < n; k++)
                  push_answer(STATUS_HIT, hit_ids[k], k == n - 1, record);
            end
         end
         default: begin
            // unused code: dropped without an answer
         end
      endcase
   endfunction

   function automatic req_type make_word(input logic [1:0] cmd, input logic [31:0] id,
                                         input box_type b);
      req_type w;
      w.command = cmd;
      w.id      = id;
      w.min_x   = b.min_x;
      w.min_y   = b.min_y;
      w.max_x   = b.max_x;
      w.max_y   = b.max_y;
      return w;
   endfunction

   // Mostly small boxes around the origin so that queries land on stored boxes.
   function automatic box_type random_box(input int unsigned span);
      box_type b;
      int      cx;
      int      cy;
      case ($urandom_range(0, 19))
         0: b = {$urandom, $urandom, $urandom, $urandom};
         1: b = FULL_BOX;
         default: begin
            cx = (int'($urandom_range(0, 96)) - 48) * 65536 + int'($urandom_range(0, 16'hFFFF));
            cy = (int'($urandom_range(0, 96)) - 48) * 65536 + int'($urandom_range(0, 16'hFFFF));
            b.min_x = cx;
            b.min_y = cy;
            b.max_x = cx + int'($urandom_range(0, span * 65536));
            b.max_y = cy + int'($urandom_range(0, span * 65536));
         end
      endcase
      return b;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [31:0] id, input box_type b,
                          input bit typed, input logic [2:0] status);
      stim_row_type row;
      row.word   = make_word(cmd, id, b);
      row.typed  = typed;
      row.status = status;
      directed_rows = {directed_rows, row};
   endtask

   // Hold start and the word until the block takes it.
   task automatic send_word(input stim_row_type row, input int unsigned gap);
      int unsigned target;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_data   <= row.word;
      cur_typed  = row.typed;
      cur_status = row.status;
      target     = taken_words + 1;
      do @(negedge clock); while (taken_words < target);
   endtask

   // Check answers first: one taken at the same edge belongs to an older word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (awaited_answers.size() == 0) begin
               note_failure($sformatf("answer with none awaited: status %0d id %h last %b",
                                      rsp_data.status, rsp_data.hit_id, rsp_data.last));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.hit_id !== want.hit_id ||
                   rsp_data.last !== want.last)
                  note_failure($sformatf(
                     "mismatch: expected status %0d id %h last %b, got %0d %h %b",
                     want.status, want.hit_id, want.last,
                     rsp_data.status, rsp_data.hit_id, rsp_data.last));
            end
         end
         if (start && !busy) begin
            taken_words++;
            advance_table(req_data, !cur_typed);
            if (cur_typed) push_answer(cur_status, '0, 1'b1, 1'b1);
         end
      end
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_row_type row;
      box_type      b;
      int unsigned  r;
      int unsigned  upd_weight;
      bit           burst;
      for (int i = 0; i < MAX_BODIES; i++) shadow_valid[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;

      add_row(CMD_REMOVE, 32'h5, FULL_BOX, 1'b1, STATUS_ABSENT);
      add_row(CMD_QUERY, '0, FULL_BOX, 1'b1, STATUS_NOHIT);
      add_row(CMD_UPDATE, 32'h0, '{0, 0, 32'h10000, 32'h10000}, 1'b1, STATUS_INSERTED);
      add_row(CMD_UPDATE, 32'hFFFFFFFF, FULL_BOX, 1'b1, STATUS_INSERTED);
      add_row(CMD_UPDATE, 32'h0, '{32'h10000, 32'h10000, 32'h30000, 32'h20000},
              1'b1, STATUS_UPDATED);
      // touching the corner counts; one step past it does not
      add_row(CMD_QUERY, '0, '{32'h30000, 32'h20000, 32'h40000, 32'h40000}, 1'b0, STATUS_HIT);
      add_row(CMD_QUERY, '0, '{32'h30001, 32'h20000, 32'h40000, 32'h40000}, 1'b0, STATUS_HIT);
      add_row(CMD_QUERY, '0, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
              1'b0, STATUS_HIT);
      add_row(CMD_QUERY, '0, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
              1'b0, STATUS_HIT);
      add_row(CMD_QUERY, '0, '{32'h40000, 32'h40000, 0, 0}, 1'b0, STATUS_HIT);
      add_row(CMD_UNUSED, 32'hFFFFFFFF, FULL_BOX, 1'b0, STATUS_HIT);
      add_row(CMD_UPDATE, 32'h80000000, '{32'h10000, 0, 0, 32'h10000}, 1'b1, STATUS_INSERTED);
      add_row(CMD_QUERY, '0, FULL_BOX, 1'b0, STATUS_HIT);
      add_row(CMD_REMOVE, 32'hFFFFFFFF, FULL_BOX, 1'b1, STATUS_REMOVED);
      add_row(CMD_REMOVE, 32'hFFFFFFFF, FULL_BOX, 1'b1, STATUS_ABSENT);
      add_row(CMD_UPDATE, 32'hFFFFFFFF, '{-32'sh50000, -32'sh50000, -32'sh10000, -32'sh10000},
              1'b1, STATUS_INSERTED);
      add_row(CMD_QUERY, '0, '{-32'sh10000, -32'sh10000, 32'h10000, 32'h10000},
              1'b0, STATUS_HIT);
      add_row(CMD_REMOVE, 32'h0, FULL_BOX, 1'b1, STATUS_REMOVED);
      add_row(CMD_QUERY, '0, FULL_BOX, 1'b0, STATUS_HIT);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i], $urandom_range(0, MAX_GAP));

      // fill the table past its capacity so that inserts get refused
      row.typed  = 1'b0;
      row.status = STATUS_UPDATED;
      for (int i = 0; i < 40; i++) begin
         row.word = make_word(CMD_UPDATE, id_pool[i + 2], random_box(16));
         send_word(row, (i < 20) ? 0 : $urandom_range(0, MAX_GAP));
      end

      for (int phase = 0; phase < 6; phase++) begin
         burst = (phase % 3 == 1);
         case (phase % 3)
            0:       upd_weight = 20;
            1:       upd_weight = 40;
            default: upd_weight = 55;
         endcase
         for (int i = 0; i < 35; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               row.word = make_word(CMD_UNUSED, $urandom, random_box(16));
            end else if (r < 4 + upd_weight) begin
               b = random_box(16);
               row.word = make_word(CMD_UPDATE, ($urandom_range(0, 9) == 0) ? $urandom :
                                    id_pool[$urandom_range(0, POOL_SIZE - 1)], b);
            end else if (r < 24 + upd_weight) begin
               row.word = make_word(CMD_REMOVE, ($urandom_range(0, 9) == 0) ? $urandom :
                                    id_pool[$urandom_range(0, POOL_SIZE - 1)], random_box(16));
            end else begin
               row.word = make_word(CMD_QUERY, $urandom, random_box(40));
            end
            send_word(row, burst ? 0 : $urandom_range(0, MAX_GAP));
         end
      end

      start <= 1'b0;
      while (awaited_answers.size() != 0) @(negedge clock);
      repeat (2 * PASS_CYCLES) @(negedge clock);
      if (fail_count == 0 && awaited_answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
